### src/sbg_pkg.sv
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared types and constants for the scaled block glyph pixel test.
// ----------------------------------------------------------------------------
package sbg_pkg;

    // configuration register indexes (byte address = 4 * index)
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned PADDR_W   = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_GLYPH_CODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd3;

    localparam logic [7:0] CHAR_FIVE  = 8'h35;  // '5', drawn with the S shape
    localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] GLYPH_CODE_RST = 8'h41;  // 'A'

    typedef enum logic [5:0] {
        GLYPH_A, GLYPH_B, GLYPH_C, GLYPH_D, GLYPH_E, GLYPH_F, GLYPH_G,
        GLYPH_H, GLYPH_I, GLYPH_J, GLYPH_K, GLYPH_L, GLYPH_M, GLYPH_N,
        GLYPH_O, GLYPH_P, GLYPH_R, GLYPH_S, GLYPH_T, GLYPH_U, GLYPH_V,
        GLYPH_W, GLYPH_X, GLYPH_Y, GLYPH_Z, GLYPH_DASH,
        GLYPH_0, GLYPH_1, GLYPH_2, GLYPH_3, GLYPH_4, GLYPH_6, GLYPH_7,
        GLYPH_8, GLYPH_NONE
    } t_glyph;

    function automatic t_glyph glyph_decode(logic [7:0] code);
        t_glyph g;
        case (code)
            "A":       g = GLYPH_A;
            "B":       g = GLYPH_B;
            "C":       g = GLYPH_C;
            "D":       g = GLYPH_D;
            "E":       g = GLYPH_E;
            "F":       g = GLYPH_F;
            "G":       g = GLYPH_G;
            "H":       g = GLYPH_H;
            "I":       g = GLYPH_I;
            "J":       g = GLYPH_J;
            "K":       g = GLYPH_K;
            "L":       g = GLYPH_L;
            "M":       g = GLYPH_M;
            "N":       g = GLYPH_N;
            "O":       g = GLYPH_O;
            "P":       g = GLYPH_P;
            "R":       g = GLYPH_R;
            "S":       g = GLYPH_S;
            CHAR_FIVE: g = GLYPH_S;
            "T":       g = GLYPH_T;
            "U":       g = GLYPH_U;
            "V":       g = GLYPH_V;
            "W":       g = GLYPH_W;
            "X":       g = GLYPH_X;
            "Y":       g = GLYPH_Y;
            "Z":       g = GLYPH_Z;
            CHAR_DASH: g = GLYPH_DASH;
            "0":       g = GLYPH_0;
            "1":       g = GLYPH_1;
            "2":       g = GLYPH_2;
            "3":       g = GLYPH_3;
            "4":       g = GLYPH_4;
            "6":       g = GLYPH_6;
            "7":       g = GLYPH_7;
            "8":       g = GLYPH_8;
            default:   g = GLYPH_NONE;
        endcase
        return g;
    endfunction

endpackage

### src/scaled_block_glyph_pixel_test.sv
// ----------------------------------------------------------------------------
// scaled_block_glyph_pixel_test
// Pixel test for a 5x5-cell block font with a programmable cell size.
// ----------------------------------------------------------------------------
// Usage:
//   APB registers: glyph_code (0x0), scale (0x4), origin_x (0x8),
//   origin_y (0xC). Write them while no word is in flight.
//   Input channel: i_valid / o_stall with i_pixel_x, i_pixel_y. A word is
//   taken on a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_pixel_on, o_glyph_unsupported.
//   An unknown glyph code gives o_pixel_on = 0, o_glyph_unsupported = 1.
//   Pipeline: a word passes through three register stages (offset
//   subtract, compare against 1..5 x scale, per-glyph rule) to o_valid.
//   Throughput: one word per cycle while i_stall is low; each pipe stage moves
//   on when it is empty or its successor moves, so bubbles collapse.
//   Receiver stall: the output word holds; o_stall rises only when all three
//   stages are full. Nothing is dropped or duplicated.
//   Reset (synchronous, active low): pipe emptied, registers back to
//   glyph 'A', scale 1, origin 0.
// ----------------------------------------------------------------------------
module scaled_block_glyph_pixel_test
    import sbg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int SCALE_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input words
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [COORD_BITS-1:0]        i_pixel_x,
    input  logic [COORD_BITS-1:0]        i_pixel_y,
    // output words
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_pixel_on,
    output logic                         o_glyph_unsupported
);

    localparam int DW    = COORD_BITS + 1;          // signed offset
    localparam int KW    = SCALE_BITS + 3;          // up to 5 x scale
    localparam int CMP_W = ((DW > KW + 1) ? DW : KW + 1);

    // ---------------- configuration ----------------
    logic [7:0]            r_glyph_code;
    logic [SCALE_BITS-1:0] r_scale;
    logic [COORD_BITS-1:0] r_origin_x;
    logic [COORD_BITS-1:0] r_origin_y;

    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_code <= GLYPH_CODE_RST;
            r_scale      <= SCALE_BITS'(1);
            r_origin_x   <= '0;
            r_origin_y   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GLYPH_CODE: r_glyph_code <= pwdata[7:0];
                REG_SCALE:      r_scale      <= pwdata[SCALE_BITS-1:0];
                REG_ORIGIN_X:   r_origin_x   <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Y:   r_origin_y   <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GLYPH_CODE: prdata = 32'(r_glyph_code);
            REG_SCALE:      prdata = 32'(r_scale);
            REG_ORIGIN_X:   prdata = 32'(r_origin_x);
            REG_ORIGIN_Y:   prdata = 32'(r_origin_y);
            default:        prdata = '0;
        endcase
    end

    // re-derived each cycle; user keeps config static while busy, unchecked
    t_glyph          r_glyph;
    logic [KW-1:0]   r_k [1:5];

    always_ff @(posedge i_clk) begin
        r_glyph <= glyph_decode(r_glyph_code);
        r_k[1]  <= KW'(r_scale);
        r_k[2]  <= KW'({r_scale, 1'b0});
        r_k[3]  <= KW'({r_scale, 1'b0}) + KW'(r_scale);
        r_k[4]  <= KW'({r_scale, 2'b00});
        r_k[5]  <= KW'({r_scale, 2'b00}) + KW'(r_scale);
    end

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_out_valid;
    logic en1, en2, en3;

    assign en3     = !r_out_valid || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) r_v1        <= i_valid;
            if (en2) r_v2        <= r_v1;
            if (en3) r_out_valid <= r_v2;
        end
    end

    // ---------------- stage 1: offsets ----------------
    logic signed [DW-1:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_dx <= $signed({1'b0, i_pixel_x}) - $signed({1'b0, r_origin_x});
            r_dy <= $signed({1'b0, i_pixel_y}) - $signed({1'b0, r_origin_y});
        end
    end

    // ---------------- stage 2: compare against 1..5 x scale ----------------
    logic signed [CMP_W-1:0] dx_ext, dy_ext;
    logic [5:1] n_xlt, n_xeq, n_ylt, n_yeq;
    logic [5:1] r_xlt, r_xeq, r_ylt, r_yeq;

    assign dx_ext = CMP_W'(r_dx);
    assign dy_ext = CMP_W'(r_dy);

    always_comb begin
        for (int i = 1; i <= 5; i++) begin
            n_xlt[i] = dx_ext <  $signed(CMP_W'(r_k[i]));
            n_xeq[i] = dx_ext == $signed(CMP_W'(r_k[i]));
            n_ylt[i] = dy_ext <  $signed(CMP_W'(r_k[i]));
            n_yeq[i] = dy_ext == $signed(CMP_W'(r_k[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_xlt <= n_xlt;
            r_xeq <= n_xeq;
            r_ylt <= n_ylt;
            r_yeq <= n_yeq;
        end
    end

    // ---------------- stage 3: glyph rule ----------------
    logic [5:1] xlt, xle, xge, xgt, ylt, yle, yge, ygt;
    logic       n_on, n_unsup;

    assign xlt = r_xlt;
    assign xle = r_xlt | r_xeq;
    assign xge = ~r_xlt;
    assign xgt = ~(r_xlt | r_xeq);
    assign ylt = r_ylt;
    assign yle = r_ylt | r_yeq;
    assign yge = ~r_ylt;
    assign ygt = ~(r_ylt | r_yeq);

    always_comb begin
        n_unsup = 1'b0;
        case (r_glyph)
            GLYPH_A: n_on = yle[1] | (yge[2] & yle[3]) | xle[1] | xge[4];
            GLYPH_B: n_on = !(xgt[1] & xlt[4] & ((ygt[1] & ylt[2]) | (ygt[3] & ylt[4])))
                          & !(xgt[4] & (ylt[1] | ygt[4] | (ygt[2] & ylt[3])));
            GLYPH_C: n_on = yle[1] | xle[1] | yge[4];
            GLYPH_D: n_on = xle[1] | (xge[1] & xle[4] & yle[1])
                          | (xge[1] & xle[4] & yge[4]) | (xge[4] & yge[1] & yle[4]);
            GLYPH_E: n_on = !(xgt[1] & ((ygt[1] & ylt[2]) | (ygt[3] & ylt[4])));
            GLYPH_F: n_on = !(xgt[1] & ((ygt[1] & ylt[2]) | ygt[3]));
            GLYPH_G: n_on = yle[1] | xle[1] | yge[4] | (xge[2] & yge[2] & yle[3])
                          | (xge[4] & yge[3]);
            GLYPH_H: n_on = (yge[2] & yle[3]) | xle[1] | xge[4];
            GLYPH_I: n_on = yle[1] | yge[4] | (xge[2] & xle[3] & yge[1] & yle[4]);
            GLYPH_J: n_on = (xge[1] & xle[4] & yle[1]) | (xge[3] & xle[4] & yle[4])
                          | (xge[1] & xle[3] & yge[4]);
            GLYPH_K: n_on = !(((ylt[1] | yge[4]) & xlt[4] & xgt[2])
                          | (yle[3] & yge[2] & xgt[3])
                          | (((ylt[2] & yge[1]) | (ygt[3] & ylt[4]))
                             & ((xgt[2] & xlt[3]) | xgt[4])));
            GLYPH_L: n_on = xle[1] | yge[4];
            GLYPH_M: n_on = xle[1] | xge[4] | (xge[1] & xle[2] & yge[1] & yle[2])
                          | (xge[2] & xle[3] & yge[2] & yle[3])
                          | (xge[3] & xle[4] & yge[1] & yle[2]);
            GLYPH_N: n_on = xle[1] | xge[4] | (xge[1] & xle[2] & yge[1] & yle[2])
                          | (xge[2] & xle[3] & yge[2] & yle[3])
                          | (xge[3] & xle[4] & yge[3] & yle[4]);
            GLYPH_O: n_on = yle[1] | yge[4] | (xle[1] & yge[1] & yle[4])
                          | (xge[4] & yge[1] & yle[4]);
            GLYPH_P: n_on = yle[1] | (yge[2] & yle[3]) | xle[1] | (xge[4] & yle[3]);
            GLYPH_R: n_on = xle[1] | yle[1] | (yge[2] & yle[3]) | (xge[4] & yle[3])
                          | (xge[3] & xle[4] & yge[3] & yle[4]) | (xge[4] & yge[4]);
            GLYPH_S: n_on = yle[1] | (yge[2] & yle[3]) | yge[4]
                          | (xle[1] & yge[1] & yle[2]) | (xge[4] & yge[3] & yle[4]);
            GLYPH_T: n_on = !(ygt[1] & (xlt[2] | xgt[3]));
            GLYPH_U: n_on = xle[1] | xge[4] | yge[4];
            GLYPH_V: n_on = ((xle[1] | xge[4]) & yle[3])
                          | (((xge[1] & xle[2]) | (xge[3] & xle[4])) & yge[3] & yle[4])
                          | (yge[4] & xle[3] & xge[2]);
            GLYPH_W: n_on = ((xle[1] | xge[4]) & yle[4])
                          | (xge[2] & xle[3] & yge[1] & yle[4])
                          | (yge[4] & ((xle[2] & xge[1]) | (xle[4] & xge[3])));
            GLYPH_X: n_on = ((xle[1] | xge[4]) & (yle[1] | yge[4]))
                          | (((xge[1] & xle[2]) | (xge[3] & xle[4]))
                             & ((yge[1] & yle[2]) | (yge[3] & yle[4])))
                          | (yge[2] & yle[3] & xle[3] & xge[2]);
            GLYPH_Y: n_on = (yle[1] & (xle[1] | xge[4]))
                          | (yge[1] & yle[2] & ((xge[1] & xle[2]) | (xge[3] & xle[4])))
                          | (yge[2] & xge[2] & xle[3]);
            GLYPH_Z: n_on = yle[1] | yge[4] | (xge[1] & xle[2] & yge[3])
                          | (xge[2] & xle[3] & yge[2] & yle[3])
                          | (xge[3] & xle[4] & yle[2]);
            GLYPH_DASH: n_on = yge[2] & yle[3];
            GLYPH_0: n_on = (xge[1] & xle[4] & (yle[1] | yge[4]))
                          | (yge[1] & yle[4] & (xle[1] | xge[4]));
            GLYPH_1: n_on = (xge[2] & xle[3]) | (yle[1] & xge[1] & xle[2]);
            GLYPH_2: n_on = (yle[1] & xge[1] & xle[3])
                          | (yle[2] & yge[1] & ((xge[3] & xlt[4]) | xle[1]))
                          | (yge[2] & yle[3] & xle[3] & xge[2])
                          | (yge[3] & yle[4] & xle[2] & xge[1])
                          | (yge[4] & xlt[4]);
            GLYPH_3: n_on = ((yle[1] | yge[4]) & xge[1] & xle[4])
                          | ((xle[1] | xge[4]) & ((yge[1] & yle[2]) | (yge[3] & yle[4])))
                          | (yge[2] & yle[3] & xge[3] & xle[4]);
            GLYPH_4: n_on = (xle[1] & yle[3]) | (yge[2] & yle[3]) | (xge[3] & xle[4]);
            GLYPH_6: n_on = !(xgt[1] & xlt[5] & ygt[1] & ylt[2])
                          & !(xgt[1] & xlt[4] & ygt[3] & ylt[4]);
            GLYPH_7: n_on = yle[1] | (yle[2] & xge[3])
                          | (yle[3] & yge[2] & xge[2] & xle[3])
                          | (yle[4] & yge[3] & xge[1] & xle[2]) | (yge[4] & xle[1]);
            GLYPH_8: n_on = !(xgt[1] & xlt[4] & ((ygt[1] & ylt[2]) | (ygt[3] & ylt[4])));
            default: begin
                n_on    = 1'b0;
                n_unsup = 1'b1;
            end
        endcase
    end

    logic r_pixel_on, r_glyph_unsupported;

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_pixel_on          <= n_on;
            r_glyph_unsupported <= n_unsup;
        end
    end

    assign o_pixel_on          = r_pixel_on;
    assign o_glyph_unsupported = r_glyph_unsupported;

endmodule
